>>> design/knnmc_pkg.sv
`default_nettype none
package knnmc_pkg;

   localparam int MaxSamples  = 1024;
   localparam int MaxFeatures = 16;
   localparam int MaxK        = 32;
   localparam int FeatBits    = 16;
   localparam int LabelBits   = 4;
   localparam int LabelSlots  = 16;
   localparam int ProdBits    = 34;
   localparam int DistBits    = 38;

   typedef enum logic [1:0] {
      CMD_TRAIN = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_PRED  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_FULL  = 2'd3;

   localparam logic REG_NEIGHBORS = 1'b0;
   localparam logic REG_FEATURES  = 1'b1;

   typedef struct packed {
      logic valid;
      logic last;
      logic clear;
   } mac_ctl_type;

endpackage
`default_nettype wire

>>> design/knnmc_mac.sv
`default_nettype none
module knnmc_mac (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire knnmc_pkg::mac_ctl_type                   ctl,
   input  wire logic signed [knnmc_pkg::FeatBits-1:0]   query_value,
   input  wire logic signed [knnmc_pkg::FeatBits-1:0]   train_value,
   output logic        [knnmc_pkg::DistBits-1:0]         dist_sum,
   output logic                                          done
);

   logic signed [knnmc_pkg::FeatBits:0]   diff;
   logic signed [knnmc_pkg::ProdBits-1:0] diff_ext;
   logic signed [knnmc_pkg::ProdBits-1:0] sq;

   logic [knnmc_pkg::ProdBits-1:0] prod_ff, prod_in;
   logic                           v2_ff, v2_in;
   logic                           l2_ff, l2_in;
   logic [knnmc_pkg::DistBits-1:0] acc_ff, acc_in;
   logic                           done_ff, done_in;

   always_comb begin
      diff     = $signed({query_value[knnmc_pkg::FeatBits-1], query_value})
               - $signed({train_value[knnmc_pkg::FeatBits-1], train_value});
      diff_ext = knnmc_pkg::ProdBits'(diff);
      sq       = diff_ext * diff_ext;
      prod_in  = sq;
      v2_in    = ctl.valid && !ctl.clear;
      l2_in    = ctl.last;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in  = acc_ff + knnmc_pkg::DistBits'(prod_ff);
         done_in = l2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v2_ff   <= v2_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      l2_ff   <= l2_in;
      acc_ff  <= acc_in;
   end

   assign dist_sum = acc_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

>>> design/knn_majority_classifier_unit.sv
`default_nettype none
// channel   direction  handshake               payload
// req_      in         req_valid/req_ready     command, feature_value, label, last
// rsp_      out        rsp_valid/rsp_ready     pred_class, winning_votes, status
// csr_      in         APB psel/penable        neighbor_count (0x0), feature_count (0x4)
// Non-last feature words, clears and dropped or empty vectors are handled without leaving ST_IDLE.
// A training vector is swept into the feature RAM by ST_STORE, zero-padded to MAX_FEATURES words.
// A query steps through ST_KROOT (square-root k when neighbor_count is 0), ST_SCAN with
// ST_SHIFT, ST_VCOUNT and ST_VPICK, paced by the single multiply-accumulate unit and the one-slot-per-cycle insertion.
// Reset is synchronous; stores need no clearing pass. req_ready drops while busy
// or while a result word waits without rsp_ready.
module knn_majority_classifier_unit #(
   parameter int MAX_SAMPLES  = knnmc_pkg::MaxSamples,
   parameter int MAX_FEATURES = knnmc_pkg::MaxFeatures,
   parameter int MAX_K        = knnmc_pkg::MaxK
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [1:0]                             req_command,
   input  wire logic signed [knnmc_pkg::FeatBits-1:0] req_feature_value,
   input  wire logic [knnmc_pkg::LabelBits-1:0]       req_label,
   input  wire logic                                   req_last,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [knnmc_pkg::LabelBits-1:0]            rsp_pred_class,
   output logic [5:0]                                  rsp_winning_votes,
   output logic [1:0]                                  rsp_status,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [2:0]                             csr_paddr,
   input  wire logic [31:0]                            csr_pwdata,
   output logic [31:0]                                 csr_prdata,
   output logic                                        csr_pready
);

   localparam int SW  = $clog2(MAX_SAMPLES + 1);
   localparam int SIW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int FPW = $clog2(MAX_FEATURES + 1);
   localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int AW  = (MAX_SAMPLES * MAX_FEATURES > 1) ?
                        $clog2(MAX_SAMPLES * MAX_FEATURES) : 1;
   localparam int KW  = $clog2(MAX_K + 1);
   localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CW  = SW + 7;
   localparam int FB  = knnmc_pkg::FeatBits;
   localparam int LB  = knnmc_pkg::LabelBits;
   localparam int DB  = knnmc_pkg::DistBits;
   localparam int NS  = knnmc_pkg::LabelSlots;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_STORE  = 7'b0000010,
      ST_KROOT  = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_SHIFT  = 7'b0010000,
      ST_VCOUNT = 7'b0100000,
      ST_VPICK  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [5:0]           nc_ff, nc_in;
   logic [4:0]           fc_ff, fc_in;
   logic [SW-1:0]        sc_ff, sc_in;
   logic signed [FB-1:0] buf_ff [MAX_FEATURES];
   logic signed [FB-1:0] buf_in [MAX_FEATURES];
   logic [FPW-1:0]       fpos_ff, fpos_in;
   logic [LB-1:0]        label_ff, label_in;
   logic [FIW-1:0]       fi_ff, fi_in;
   logic [AW-1:0]        base_ff, base_in;
   logic                 issue_ff, issue_in;
   logic                 v1_ff, v1_in;
   logic                 l1_ff, l1_in;
   logic [SIW-1:0]       s_ff, s_in;
   logic [SW-1:0]        r_ff, r_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [KW-1:0]        filled_ff, filled_in;
   logic [KW-1:0]        pos_ff, pos_in;
   logic [DB-1:0]        nd_ff [MAX_K];
   logic [DB-1:0]        nd_in [MAX_K];
   logic [LB-1:0]        nl_ff [MAX_K];
   logic [LB-1:0]        nl_in [MAX_K];
   logic [KW-1:0]        votes_ff [NS];
   logic [KW-1:0]        votes_in [NS];
   logic [LB-1:0]        c_ff, c_in;
   logic [LB-1:0]        best_ff, best_in;
   logic [KW-1:0]        bestv_ff, bestv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LB-1:0]        rsp_class_ff, rsp_class_in;
   logic [5:0]           rsp_votes_ff, rsp_votes_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic signed [FB-1:0] feat_mem [MAX_SAMPLES*MAX_FEATURES];
   logic [LB-1:0]        label_mem [MAX_SAMPLES];
   logic signed [FB-1:0] fdata_ff;
   logic signed [FB-1:0] qv_ff;
   logic [LB-1:0]        lab_rd_ff;

   logic                 req_fire, csr_wr;
   logic [FPW-1:0]       nf;
   logic [AW-1:0]        mem_addr;
   logic                 feat_we, label_we;
   logic signed [FB-1:0] feat_wdata;
   logic [KW-1:0]        idx;
   logic [KW-1:0]        kl;
   logic [SW:0]          rp1;
   logic [2*SW+1:0]      root_sq;
   logic [CW-1:0]        kraw;
   logic                 upd;
   logic [LB-1:0]        nb;
   logic [KW-1:0]        nv;
   knnmc_pkg::mac_ctl_type mac_ctl;
   logic [DB-1:0]        mac_dist;
   logic                 mac_done;
   logic                 mac_clear;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign mem_addr   = base_ff + AW'(fi_ff);
   assign idx        = pos_ff - KW'(1);
   assign kl         = k_ff - KW'(1);
   assign rp1        = (SW+1)'(r_ff) + (SW+1)'(1);
   assign root_sq    = (2*SW+2)'(rp1) * (2*SW+2)'(rp1);

   always_comb begin
      if (fc_ff == 5'd0) begin
         nf = FPW'(1);
      end else if (32'(fc_ff) > 32'(MAX_FEATURES)) begin
         nf = FPW'(MAX_FEATURES);
      end else begin
         nf = FPW'(fc_ff);
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         knnmc_pkg::REG_NEIGHBORS: csr_prdata = 32'(nc_ff);
         knnmc_pkg::REG_FEATURES:  csr_prdata = 32'(fc_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_comb begin
      nc_in = nc_ff;
      fc_in = fc_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            knnmc_pkg::REG_NEIGHBORS: nc_in = csr_pwdata[5:0];
            knnmc_pkg::REG_FEATURES:  fc_in = csr_pwdata[4:0];
            default:                  nc_in = nc_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      sc_in         = sc_ff;
      buf_in        = buf_ff;
      fpos_in       = fpos_ff;
      label_in      = label_ff;
      fi_in         = fi_ff;
      base_in       = base_ff;
      issue_in      = issue_ff;
      v1_in         = issue_ff;
      l1_in         = issue_ff && (FPW'(fi_ff) + FPW'(1) == nf);
      s_in          = s_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      filled_in     = filled_ff;
      pos_in        = pos_ff;
      nd_in         = nd_ff;
      nl_in         = nl_ff;
      votes_in      = votes_ff;
      c_in          = c_ff;
      best_in       = best_ff;
      bestv_in      = bestv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_class_in  = rsp_class_ff;
      rsp_votes_in  = rsp_votes_ff;
      rsp_status_in = rsp_status_ff;
      feat_we       = 1'b0;
      label_we      = 1'b0;
      feat_wdata    = '0;
      mac_clear     = 1'b0;
      kraw          = '0;
      upd           = 1'b0;
      nb            = best_ff;
      nv            = bestv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  knnmc_pkg::CMD_CLEAR: begin
                     sc_in         = '0;
                     fpos_in       = '0;
                     for (int i = 0; i < MAX_FEATURES; i++) buf_in[i] = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_class_in  = '0;
                     rsp_votes_in  = '0;
                     rsp_status_in = knnmc_pkg::STAT_DONE;
                  end
                  knnmc_pkg::CMD_TRAIN, knnmc_pkg::CMD_QUERY: begin
                     if (fpos_ff < nf) begin
                        buf_in[fpos_ff[FIW-1:0]] = req_feature_value;
                        fpos_in = fpos_ff + FPW'(1);
                     end
                     if (req_last) begin
                        rsp_class_in = '0;
                        rsp_votes_in = '0;
                        if (req_command == knnmc_pkg::CMD_TRAIN) begin
                           if (32'(sc_ff) >= 32'(MAX_SAMPLES)) begin
                              rsp_valid_in  = 1'b1;
                              rsp_status_in = knnmc_pkg::STAT_FULL;
                              fpos_in       = '0;
                              for (int i = 0; i < MAX_FEATURES; i++) buf_in[i] = '0;
                           end else begin
                              label_in = req_label;
                              fi_in    = '0;
                              base_in  = AW'(sc_ff) * AW'(MAX_FEATURES);
                              state_in = ST_STORE;
                           end
                        end else if (sc_ff == '0) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = knnmc_pkg::STAT_EMPTY;
                           fpos_in       = '0;
                           for (int i = 0; i < MAX_FEATURES; i++) buf_in[i] = '0;
                        end else begin
                           r_in     = '0;
                           state_in = ST_KROOT;
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_STORE: begin
            feat_we    = 1'b1;
            feat_wdata = (FPW'(fi_ff) < nf) ? buf_ff[fi_ff] : '0;
            label_we   = (fi_ff == '0);
            if (fi_ff == FIW'(MAX_FEATURES - 1)) begin
               sc_in         = sc_ff + SW'(1);
               fpos_in       = '0;
               for (int i = 0; i < MAX_FEATURES; i++) buf_in[i] = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = knnmc_pkg::STAT_DONE;
               state_in      = ST_IDLE;
            end else begin
               fi_in = fi_ff + FIW'(1);
            end
         end

         ST_KROOT: begin
            if (nc_ff == '0 && root_sq <= (2*SW+2)'(sc_ff)) begin
               r_in = r_ff + SW'(1);
            end else begin
               kraw = (nc_ff != '0) ? CW'(nc_ff) : CW'(r_ff);
               if (kraw > CW'(sc_ff)) kraw = CW'(sc_ff);
               if (kraw > CW'(MAX_K)) kraw = CW'(MAX_K);
               if (kraw == '0) kraw = CW'(1);
               k_in      = KW'(kraw);
               s_in      = '0;
               base_in   = '0;
               fi_in     = '0;
               issue_in  = 1'b1;
               filled_in = '0;
               mac_clear = 1'b1;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (issue_ff) begin
               if (FPW'(fi_ff) + FPW'(1) == nf) begin
                  issue_in = 1'b0;
               end else begin
                  fi_in = fi_ff + FIW'(1);
               end
            end
            if (mac_done) begin
               if (filled_ff < k_ff) begin
                  pos_in    = filled_ff;
                  filled_in = filled_ff + KW'(1);
                  state_in  = ST_SHIFT;
               end else if (mac_dist < nd_ff[kl[KIW-1:0]]) begin
                  pos_in   = kl;
                  state_in = ST_SHIFT;
               end else if (SW'(s_ff) + SW'(1) == sc_ff) begin
                  for (int i = 0; i < NS; i++) votes_in[i] = '0;
                  pos_in   = filled_ff;
                  state_in = ST_VCOUNT;
               end else begin
                  s_in      = s_ff + SIW'(1);
                  base_in   = base_ff + AW'(MAX_FEATURES);
                  fi_in     = '0;
                  issue_in  = 1'b1;
                  mac_clear = 1'b1;
               end
            end
         end

         ST_SHIFT: begin
            if (pos_ff != '0 && nd_ff[idx[KIW-1:0]] > mac_dist) begin
               nd_in[pos_ff[KIW-1:0]] = nd_ff[idx[KIW-1:0]];
               nl_in[pos_ff[KIW-1:0]] = nl_ff[idx[KIW-1:0]];
               pos_in                 = idx;
            end else begin
               nd_in[pos_ff[KIW-1:0]] = mac_dist;
               nl_in[pos_ff[KIW-1:0]] = lab_rd_ff;
               if (SW'(s_ff) + SW'(1) == sc_ff) begin
                  for (int i = 0; i < NS; i++) votes_in[i] = '0;
                  pos_in   = filled_ff;
                  state_in = ST_VCOUNT;
               end else begin
                  s_in      = s_ff + SIW'(1);
                  base_in   = base_ff + AW'(MAX_FEATURES);
                  fi_in     = '0;
                  issue_in  = 1'b1;
                  mac_clear = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_VCOUNT: begin
            if (pos_ff != '0) begin
               votes_in[nl_ff[idx[KIW-1:0]]] = votes_ff[nl_ff[idx[KIW-1:0]]] + KW'(1);
               pos_in = idx;
            end else begin
               c_in     = '0;
               best_in  = '0;
               bestv_in = '0;
               state_in = ST_VPICK;
            end
         end

         ST_VPICK: begin
            upd      = votes_ff[c_ff] > bestv_ff;
            nb       = upd ? c_ff : best_ff;
            nv       = upd ? votes_ff[c_ff] : bestv_ff;
            best_in  = nb;
            bestv_in = nv;
            if (c_ff == LB'(NS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_class_in  = nb;
               rsp_votes_in  = 6'(nv);
               rsp_status_in = knnmc_pkg::STAT_PRED;
               fpos_in       = '0;
               for (int i = 0; i < MAX_FEATURES; i++) buf_in[i] = '0;
               state_in      = ST_IDLE;
            end else begin
               c_in = c_ff + LB'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mac_ctl.valid = v1_ff;
   assign mac_ctl.last  = l1_ff;
   assign mac_ctl.clear = mac_clear;

   knnmc_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mac_ctl),
      .query_value (qv_ff),
      .train_value (fdata_ff),
      .dist_sum    (mac_dist),
      .done        (mac_done)
   );

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[mem_addr] <= feat_wdata;
      end
      fdata_ff <= feat_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (label_we) begin
         label_mem[sc_ff[SIW-1:0]] <= label_ff;
      end
      lab_rd_ff <= label_mem[s_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nc_ff        <= '0;
         fc_ff        <= 5'd16;
         sc_ff        <= '0;
         fpos_ff      <= '0;
         for (int i = 0; i < MAX_FEATURES; i++) buf_ff[i] <= '0;
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         l1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nc_ff        <= nc_in;
         fc_ff        <= fc_in;
         sc_ff        <= sc_in;
         fpos_ff      <= fpos_in;
         buf_ff       <= buf_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         l1_ff        <= l1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      label_ff      <= label_in;
      fi_ff         <= fi_in;
      base_ff       <= base_in;
      s_ff          <= s_in;
      r_ff          <= r_in;
      k_ff          <= k_in;
      filled_ff     <= filled_in;
      pos_ff        <= pos_in;
      nd_ff         <= nd_in;
      nl_ff         <= nl_in;
      votes_ff      <= votes_in;
      c_ff          <= c_in;
      best_ff       <= best_in;
      bestv_ff      <= bestv_in;
      qv_ff         <= buf_ff[fi_ff];
      rsp_class_ff  <= rsp_class_in;
      rsp_votes_ff  <= rsp_votes_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pred_class    = rsp_class_ff;
   assign rsp_winning_votes = rsp_votes_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
`default_nettype wire
